@@ rtl/grt_pkg.sv @@
package grt_pkg;

  localparam int MAP_COLS   = 64;
  localparam int MAP_ROWS   = 64;
  localparam int CELL_W     = 6;
  localparam int DIST_W     = 32;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int COL_AW    = $clog2(MAP_COLS);
  localparam int ROW_AW    = $clog2(MAP_ROWS);
  localparam int MEM_DEPTH = MAP_COLS * MAP_ROWS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int MAX_AW    = (COL_AW > ROW_AW) ? COL_AW : ROW_AW;
  // coordinate width: holds a start cell, the map size and one step past either end
  localparam int CRD_W     = ((CELL_W > MAX_AW) ? CELL_W : MAX_AW) + 2;

  localparam logic [DIST_W-1:0]    DIST_MAX       = '1;
  localparam logic                 REQ_WRITE      = 1'b0;
  localparam logic                 REQ_CAST       = 1'b1;
  localparam logic                 WALL_MARK      = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = CFG_IDX_W'(1);
  localparam logic [DIM_W-1:0]     DIM_RESET      = DIM_W'(64);

  typedef struct packed {
    logic              req_type;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              wall_bit;
    logic              step_x_neg;
    logic              step_y_neg;
    logic [DIST_W-1:0] next_x_dist;
    logic [DIST_W-1:0] next_y_dist;
    logic [DIST_W-1:0] delta_x;
    logic [DIST_W-1:0] delta_y;
  } req_t;

  typedef struct packed {
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic              last_axis;
    logic              out_of_map;
    logic [DIST_W-1:0] final_x_dist;
    logic [DIST_W-1:0] final_y_dist;
  } res_t;

  typedef struct packed {
    logic clr_wr;
    logic map_wr;
    logic load;
    logic step;
    logic rd;
    logic res_ld;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic outside;
    logic wall;
  } ctl_sts_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

endpackage

@@ rtl/grt_ctrl.sv @@
module grt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              req_type_i,
  input  grt_pkg::ctl_sts_t sts_i,
  output grt_pkg::ctl_cmd_t cmd_o,
  output logic              busy_o,
  output logic              res_valid_o
);
  import grt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_LOOK,
    ST_TEST
  } state_e;

  state_e   state_q, state_d;
  logic     res_valid_q;
  ctl_cmd_t cmd;

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == REQ_CAST) begin
            cmd.load = 1'b1;
            state_d  = ST_STEP;
          end else begin
            cmd.map_wr = 1'b1;
          end
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        state_d  = ST_LOOK;
      end
      ST_LOOK: begin
        if (sts_i.outside) begin
          cmd.res_ld = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd.rd  = 1'b1;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts_i.wall) begin
          cmd.res_ld = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
          state_d  = ST_LOOK;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= cmd.res_ld;
    end
  end

  assign cmd_o       = cmd;
  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;

endmodule

@@ rtl/grt_datapath.sv @@
module grt_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  grt_pkg::req_t                      req_i,
  input  logic                               cfg_valid_i,
  input  logic [grt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [grt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  grt_pkg::ctl_cmd_t                  cmd_i,
  output grt_pkg::ctl_sts_t                  sts_o,
  output grt_pkg::res_t                      res_o
);
  import grt_pkg::*;

  logic [DIM_W-1:0]  map_width_q, map_height_q;
  logic [MEM_AW-1:0] clr_q;
  logic [CRD_W-1:0]  cx_q, cy_q;
  logic              xneg_q, yneg_q, side_q;
  logic [DIST_W-1:0] dx_q, dy_q, ddx_q, ddy_q;
  logic              rd_q;
  res_t              res_q;

  logic              mem [MEM_DEPTH];
  logic              mem_we, mem_wd, wr_in;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [CRD_W-1:0]  cols_lim, rows_lim;
  logic              outside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= DIM_RESET;
      map_height_q <= DIM_RESET;
      clr_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_MAP_WIDTH) begin
        map_width_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_MAP_HEIGHT) begin
        map_height_q <= cfg_data_i;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + MEM_AW'(1);
      end
    end
  end

  always_comb begin
    if (map_width_q == '0) begin
      cols_lim = CRD_W'(1);
    end else if (CRD_W'(map_width_q) > CRD_W'(MAP_COLS)) begin
      cols_lim = CRD_W'(MAP_COLS);
    end else begin
      cols_lim = CRD_W'(map_width_q);
    end
    if (map_height_q == '0) begin
      rows_lim = CRD_W'(1);
    end else if (CRD_W'(map_height_q) > CRD_W'(MAP_ROWS)) begin
      rows_lim = CRD_W'(MAP_ROWS);
    end else begin
      rows_lim = CRD_W'(map_height_q);
    end
  end

  // a step below zero wraps to all ones, which also fails the upper bound
  assign outside = (cx_q >= cols_lim) || (cy_q >= rows_lim);

  assign wr_in  = (CRD_W'(req_i.cell_x) < CRD_W'(MAP_COLS)) &&
                  (CRD_W'(req_i.cell_y) < CRD_W'(MAP_ROWS));
  assign mem_we = cmd_i.clr_wr || (cmd_i.map_wr && wr_in);
  assign mem_wd = cmd_i.clr_wr ? 1'b0 : req_i.wall_bit;
  assign mem_wa = cmd_i.clr_wr ? clr_q :
                  MEM_AW'(req_i.cell_y) * MEM_AW'(MAP_COLS) + MEM_AW'(req_i.cell_x);
  assign mem_ra = MEM_AW'(cy_q) * MEM_AW'(MAP_COLS) + MEM_AW'(cx_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q   <= CRD_W'(req_i.cell_x);
      cy_q   <= CRD_W'(req_i.cell_y);
      xneg_q <= req_i.step_x_neg;
      yneg_q <= req_i.step_y_neg;
      dx_q   <= req_i.next_x_dist;
      dy_q   <= req_i.next_y_dist;
      ddx_q  <= req_i.delta_x;
      ddy_q  <= req_i.delta_y;
    end else if (cmd_i.step) begin
      if (dx_q < dy_q) begin
        dx_q   <= sat_add(dx_q, ddx_q);
        cx_q   <= xneg_q ? cx_q - CRD_W'(1) : cx_q + CRD_W'(1);
        side_q <= 1'b0;
      end else begin
        dy_q   <= sat_add(dy_q, ddy_q);
        cy_q   <= yneg_q ? cy_q - CRD_W'(1) : cy_q + CRD_W'(1);
        side_q <= 1'b1;
      end
    end
    if (cmd_i.res_ld) begin
      res_q.hit_x        <= outside ? '0 : cx_q[CELL_W-1:0];
      res_q.hit_y        <= outside ? '0 : cy_q[CELL_W-1:0];
      res_q.last_axis    <= side_q;
      res_q.out_of_map   <= outside;
      res_q.final_x_dist <= dx_q;
      res_q.final_y_dist <= dy_q;
    end
  end

  assign sts_o.clr_last = (clr_q == MEM_AW'(MEM_DEPTH - 1));
  assign sts_o.outside  = outside;
  assign sts_o.wall     = (rd_q == WALL_MARK);
  assign res_o          = res_q;

endmodule

@@ rtl/grid_ray_traversal.sv @@
// Grid ray traversal over a stored wall bitmap.
// Requests: raise start_i with req_i while busy_o is low; the transfer
// happens at that edge. A write request (req_type 0) stores one map bit
// in that cycle, gives no result, and the block is ready again at once.
// A cast request (req_type 1) walks the map one cell per step and gives
// one result on res_o, marked by res_valid_o for exactly one cycle.
// A cast does one step update per cell and, while the cell is inside the map,
// one map read; busy_o stays high until the walk leaves the map or ends on
// a wall; the result strobe comes in the first cycle with busy low. A new
// request may be taken in that strobe cycle.
// The receiver cannot stall; results are not held.
// Config: cfg_valid_i/cfg_ready_o transfer cfg_data_i to register
// cfg_index_i (0 map width, 1 map height); ready is always high.
// Write config only while idle.
// Reset: width and height go to 64 and the map is cleared by a pass over
// all 4096 cells, one cell a cycle, with busy_o high throughout.
module grid_ray_traversal (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  grt_pkg::req_t                  req_i,
  output logic                           res_valid_o,
  output grt_pkg::res_t                  res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [grt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [grt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import grt_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  grt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_type_i  (req_i.req_type),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o)
  );

  grt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 300;
  localparam int REQ_W = $bits(req_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic res_valid_o;
  res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  grid_ray_traversal i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow of the block state
  bit wall_bits [MEM_DEPTH];
  logic [DIM_W-1:0] cur_width = DIM_RESET;
  logic [DIM_W-1:0] cur_height = DIM_RESET;

  req_t req_backlog[$];
  res_t predicted_hits[$];
  int bad_hits = 0;
  bit steady_feed = 1'b0;
  bit feed_next;
  res_t hit_want;
  bit hit_ok;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int map_span(input logic [DIM_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic logic [DIST_W-1:0] dist_sum(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
    logic [DIST_W-1:0] s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  function automatic res_t trace_ray(input req_t rq);
    int x, y, sx, sy, w, h;
    logic [DIST_W-1:0] nx, ny;
    logic side, outside, done;
    res_t r;
    w = map_span(cur_width, MAP_COLS);
    h = map_span(cur_height, MAP_ROWS);
    x = int'(rq.cell_x);
    y = int'(rq.cell_y);
    sx = rq.step_x_neg ? -1 : 1;
    sy = rq.step_y_neg ? -1 : 1;
    nx = rq.next_x_dist;
    ny = rq.next_y_dist;
    side = 1'b0;
    outside = 1'b0;
    done = 1'b0;
    while (!done) begin
      if (nx < ny) begin
        nx = dist_sum(nx, rq.delta_x);
        x += sx;
        side = 1'b0;
      end else begin
        ny = dist_sum(ny, rq.delta_y);
        y += sy;
        side = 1'b1;
      end
      if (x < 0 || y < 0 || x >= w || y >= h) begin
        outside = 1'b1;
        done = 1'b1;
      end else if (wall_bits[y * MAP_COLS + x] == WALL_MARK) begin
        done = 1'b1;
      end
    end
    r.hit_x = outside ? '0 : CELL_W'(x);
    r.hit_y = outside ? '0 : CELL_W'(y);
    r.last_axis = side;
    r.out_of_map = outside;
    r.final_x_dist = nx;
    r.final_y_dist = ny;
    return r;
  endfunction

  function automatic req_t mk_write(input int x, input int y, input logic wall);
    req_t rq;
    rq = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    rq.req_type = REQ_WRITE;
    rq.cell_x = CELL_W'(x);
    rq.cell_y = CELL_W'(y);
    rq.wall_bit = wall;
    return rq;
  endfunction

  function automatic req_t mk_cast(input int x, input int y, input logic sxn,
                                   input logic syn, input logic [DIST_W-1:0] nx,
                                   input logic [DIST_W-1:0] ny,
                                   input logic [DIST_W-1:0] dx,
                                   input logic [DIST_W-1:0] dy);
    req_t rq;
    rq.req_type = REQ_CAST;
    rq.cell_x = CELL_W'(x);
    rq.cell_y = CELL_W'(y);
    rq.wall_bit = 1'($urandom_range(1));
    rq.step_x_neg = sxn;
    rq.step_y_neg = syn;
    rq.next_x_dist = nx;
    rq.next_y_dist = ny;
    rq.delta_x = dx;
    rq.delta_y = dy;
    return rq;
  endfunction

  function automatic req_t random_item(input int density);
    int w, h, x, y, mode;
    logic [DIST_W-1:0] nx, ny, dx, dy;
    w = map_span(cur_width, MAP_COLS);
    h = map_span(cur_height, MAP_ROWS);
    if ($urandom_range(99) < 35) begin
      if ($urandom_range(99) < 75) begin
        x = $urandom_range(w - 1);
        y = $urandom_range(h - 1);
      end else begin
        x = $urandom_range(63);
        y = $urandom_range(63);
      end
      return mk_write(x, y, $urandom_range(99) < density);
    end
    if ($urandom_range(99) < 90) begin
      x = $urandom_range(w - 1);
      y = $urandom_range(h - 1);
    end else begin
      x = $urandom_range(63);
      y = $urandom_range(63);
    end
    mode = $urandom_range(9);
    case (mode)
      0: begin
        nx = $urandom();
        ny = $urandom();
        dx = $urandom();
        dy = $urandom();
      end
      1: begin
        dx = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
        dy = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
        nx = $urandom();
        ny = $urandom();
      end
      2: begin
        dx = $urandom_range(1) ? '0 : DIST_W'($urandom_range(32'h0002_0000));
        dy = $urandom_range(1) ? '0 : DIST_W'($urandom_range(32'h0002_0000));
        nx = $urandom_range(1) ? '0 : dx;
        ny = $urandom_range(1) ? '0 : dy;
      end
      default: begin
        dx = $urandom_range(32'h0008_0000, 32'h0000_4000);
        dy = $urandom_range(32'h0008_0000, 32'h0000_4000);
        nx = $urandom_range(dx);
        ny = $urandom_range(dy);
      end
    endcase
    return mk_cast(x, y, 1'($urandom_range(1)), 1'($urandom_range(1)), nx, ny, dx, dy);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        if (req_i.req_type == REQ_WRITE) begin
          wall_bits[int'(req_i.cell_y) * MAP_COLS + int'(req_i.cell_x)] = req_i.wall_bit;
        end else begin
          predicted_hits.push_back(trace_ray(req_i));
        end
      end
      if (start_i && busy_o) begin
        feed_next = 1'b1;
      end else begin
        feed_next = req_backlog.size() != 0 &&
                    (steady_feed || $urandom_range(99) >= 38);
        if (feed_next) req_i <= req_backlog.pop_front();
      end
      start_i <= feed_next;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (predicted_hits.size() == 0) begin
        bad_hits++;
        if (bad_hits <= 10) $display("result with no cast pending: %p", res_o);
      end else begin
        hit_want = predicted_hits.pop_front();
        hit_ok = res_o.hit_x === hit_want.hit_x &&
                 res_o.hit_y === hit_want.hit_y &&
                 res_o.last_axis === hit_want.last_axis &&
                 res_o.out_of_map === hit_want.out_of_map &&
                 res_o.final_x_dist === hit_want.final_x_dist &&
                 res_o.final_y_dist === hit_want.final_y_dist;
        if (!hit_ok) begin
          bad_hits++;
          if (bad_hits <= 10) begin
            $display("hit mismatch exp x=%0d y=%0d side=%b out=%b dx=%h dy=%h",
                     hit_want.hit_x, hit_want.hit_y, hit_want.last_axis,
                     hit_want.out_of_map, hit_want.final_x_dist, hit_want.final_y_dist);
            $display("             got x=%0d y=%0d side=%b out=%b dx=%h dy=%h",
                     res_o.hit_x, res_o.hit_y, res_o.last_axis,
                     res_o.out_of_map, res_o.final_x_dist, res_o.final_y_dist);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MAP_WIDTH) cur_width = val;
    else if (idx == CFG_MAP_HEIGHT) cur_height = val;
    cfg_valid_i <= 1'b0;
  endtask

  // wait for the backlog to drain and every cast to report
  task automatic settle();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || start_i || predicted_hits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [DIM_W-1:0] widths [NUM_PHASES];
    logic [DIM_W-1:0] heights [NUM_PHASES];
    int density;
    widths = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd17, 7'd40};
    heights = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd64, 7'd9, 7'd33};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy_o);

    // walks on an empty map, wall hits on either side, edge exits
    req_backlog.push_back(mk_cast(0, 0, 0, 0, 0, 1, 1, 1));
    req_backlog.push_back(mk_write(5, 0, 1));
    req_backlog.push_back(mk_cast(0, 0, 0, 0, 0, '1, 32'h1_0000, 32'h1_0000));
    req_backlog.push_back(mk_write(0, 3, 1));
    req_backlog.push_back(mk_cast(0, 0, 0, 0, 0, 0, 0, 0));
    req_backlog.push_back(mk_cast(0, 0, 1, 0, 0, 1, 32'h8000, 32'h8000));
    req_backlog.push_back(mk_cast(0, 0, 0, 1, 5, 5, 32'h8000, 32'h8000));
    req_backlog.push_back(mk_cast(63, 63, 0, 0, 0, 1, 32'h8000, 32'h8000));
    req_backlog.push_back(mk_cast(63, 63, 0, 0, 7, 7, 32'h8000, 32'h8000));
    // saturating distances
    req_backlog.push_back(mk_cast(10, 10, 1, 1, 32'hFFFF_FFFE, '1, '1, '1));
    req_backlog.push_back(mk_write(63, 63, 1));
    req_backlog.push_back(mk_cast(63, 60, 0, 0, 3, 3, 32'h1_0000, 32'h1_0000));
    // start cell on a wall is skipped
    req_backlog.push_back(mk_cast(5, 0, 0, 0, 0, '1, 32'h1_0000, 32'h1_0000));
    req_backlog.push_back(mk_write(5, 0, 0));
    req_backlog.push_back(mk_cast(0, 0, 0, 0, 0, '1, 32'h1_0000, 32'h1_0000));
    req_backlog.push_back({REQ_WRITE, {($bits(req_t) - 1){1'b1}}});
    req_backlog.push_back('1);
    req_backlog.push_back({REQ_CAST, {($bits(req_t) - 1){1'b0}}});
    req_backlog.push_back(mk_write(63, 63, 0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_reg(CFG_MAP_WIDTH, widths[ph]);
      write_reg(CFG_MAP_HEIGHT, heights[ph]);
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom()));
      steady_feed = (ph == 3);
      density = $urandom_range(45, 5);
      for (int n = 0; n < PHASE_ITEMS; n++) req_backlog.push_back(random_item(density));
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (predicted_hits.size() != 0) begin
      bad_hits += predicted_hits.size();
      $display("%0d casts without a result", predicted_hits.size());
    end
    if (bad_hits == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
